// ----- design/xts_pkg.sv -----
// Shared types, constants and AES round functions for the XTS-AES cipher.
// Used by xts_ctrl, xts_dp and xts_aes_block_cipher; depends on nothing.
package xts_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXPAND,
    S_ADDK,
    S_ROUND,
    S_FINISH
  } xts_state_t;

  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_BLOCK = 2'd2;

  localparam logic REG_KEY_LENGTH = 1'b0;
  localparam logic REG_DIRECTION  = 1'b1;

  // Counter loads: forward key steps before decrypting and rounds, each minus one
  localparam logic [3:0] EXP_LAST_128 = 4'd9;
  localparam logic [3:0] EXP_LAST_256 = 4'd12;
  localparam logic [3:0] RND_LAST_128 = 4'd9;
  localparam logic [3:0] RND_LAST_256 = 4'd13;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] GF128_POLY = 8'h87;
  localparam logic [7:0] GF128_NONE = 8'h00;

  typedef struct packed {
    logic capture;    // load block and key window
    logic load_tweak; // capture a start item
    logic key_wr;
    logic fwd;        // forward key schedule step
    logic bwd;        // backward key schedule step
    logic add_key;
    logic round;
    logic last;       // final round: no (inverse) MixColumns
    logic dec;
    logic tweak_job;
    logic finish;
  } xts_cmd_t;

  typedef struct packed {
    logic klen;
    logic dir;
    logic out_full;
  } xts_status_t;

  typedef logic [7:0] sbox_tbl_t [256];

  localparam sbox_tbl_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic sbox_tbl_t build_inv_sbox();
    sbox_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]] = i[7:0];
    end
    return t;
  endfunction

  localparam sbox_tbl_t INV_SBOX = build_inv_sbox();

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] inv_xt(input logic [7:0] a);
    logic [7:0] t;
    t = a ^ 8'h1b;
    return a[0] ? {1'b1, t[7:1]} : {1'b0, a[7:1]};
  endfunction

  // Schedule core: RotWord+SubWord+Rcon, or SubWord only
  function automatic logic [31:0] key_core(input logic [31:0] w, input logic [7:0] rc,
                                           input logic rot);
    logic [31:0] r;
    r = rot ? {w[7:0], w[31:8]} : w;
    for (int k = 0; k < 4; k++) begin
      r[8*k +: 8] = SBOX[r[8*k +: 8]];
    end
    if (rot) begin
      r[7:0] = r[7:0] ^ rc;
    end
    return r;
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [127:0] u;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        u[8*(i+4*c) +: 8] = SBOX[s[8*(i+4*((c+i)%4)) +: 8]];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = u[32*c +: 8];
        a1 = u[32*c+8 +: 8];
        a2 = u[32*c+16 +: 8];
        a3 = u[32*c+24 +: 8];
        u[32*c +: 8]    = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        u[32*c+8 +: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        u[32*c+16 +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        u[32*c+24 +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
    end
    return u ^ k;
  endfunction

  function automatic logic [7:0] gm9(input logic [7:0] a);
    return xt(xt(xt(a))) ^ a;
  endfunction

  function automatic logic [7:0] gm11(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(a) ^ a;
  endfunction

  function automatic logic [7:0] gm13(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
  endfunction

  function automatic logic [7:0] gm14(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [127:0] u;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        u[8*(i+4*((c+i)%4)) +: 8] = INV_SBOX[s[8*(i+4*c) +: 8]];
      end
    end
    u = u ^ k;
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = u[32*c +: 8];
        a1 = u[32*c+8 +: 8];
        a2 = u[32*c+16 +: 8];
        a3 = u[32*c+24 +: 8];
        u[32*c +: 8]    = gm14(a0) ^ gm11(a1) ^ gm13(a2) ^ gm9(a3);
        u[32*c+8 +: 8]  = gm9(a0) ^ gm14(a1) ^ gm11(a2) ^ gm13(a3);
        u[32*c+16 +: 8] = gm13(a0) ^ gm9(a1) ^ gm14(a2) ^ gm11(a3);
        u[32*c+24 +: 8] = gm11(a0) ^ gm13(a1) ^ gm9(a2) ^ gm14(a3);
      end
    end
    return u;
  endfunction

endpackage

// ----- design/xts_ctrl.sv -----
// Sequencer for the XTS-AES cipher: accepts items, counts key steps and rounds.
// Depends on xts_pkg; drives xts_dp through xts_cmd_t.
module xts_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  input  xts_pkg::xts_status_t  status,
  output xts_pkg::xts_cmd_t     cmd
);
  import xts_pkg::*;

  xts_state_t state, state_next;
  logic [3:0] cnt, cnt_next;
  logic job_tweak, job_tweak_next;
  logic job_dec, job_dec_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      job_tweak <= 1'b0;
      job_dec   <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      job_tweak <= job_tweak_next;
      job_dec   <= job_dec_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    job_tweak_next = job_tweak;
    job_dec_next   = job_dec;
    case (state)
      S_IDLE: begin
        if (in_valid && opcode == OP_START) begin
          job_tweak_next = 1'b1;
          job_dec_next   = 1'b0;
          state_next     = S_ADDK;
        end else if (in_valid && opcode == OP_BLOCK) begin
          job_tweak_next = 1'b0;
          job_dec_next   = status.dir;
          if (status.dir) begin
            state_next = S_EXPAND;
            cnt_next   = status.klen ? EXP_LAST_256 : EXP_LAST_128;
          end else begin
            state_next = S_ADDK;
          end
        end
      end
      S_EXPAND: begin
        if (cnt == '0) begin
          state_next = S_ADDK;
        end else begin
          cnt_next = cnt - 4'd1;
        end
      end
      S_ADDK: begin
        cnt_next   = status.klen ? RND_LAST_256 : RND_LAST_128;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        if (cnt == '0) begin
          state_next = S_FINISH;
        end else begin
          cnt_next = cnt - 4'd1;
        end
      end
      S_FINISH: begin
        if (job_tweak || !status.out_full) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.tweak_job = job_tweak;
    cmd.dec       = job_dec;
    in_stall      = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall       = 1'b0;
        cmd.key_wr     = in_valid && opcode == OP_KEY;
        cmd.capture    = in_valid && (opcode == OP_START || opcode == OP_BLOCK);
        cmd.load_tweak = opcode == OP_START;
      end
      S_EXPAND: begin
        cmd.fwd = 1'b1;
      end
      S_ADDK: begin
        cmd.add_key = 1'b1;
        cmd.fwd     = !job_dec;
        cmd.bwd     = job_dec;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        cmd.last  = cnt == '0;
        cmd.fwd   = !job_dec;
        cmd.bwd   = job_dec;
      end
      S_FINISH: begin
        cmd.finish = job_tweak || !status.out_full;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  a_no_double_step: assert property (@(posedge clk) disable iff (rst)
    !(cmd.fwd && cmd.bwd)) else $error("forward and backward key step together");

  a_busy_after_job: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (opcode == OP_START || opcode == OP_BLOCK))
    |=> state != S_IDLE) else $error("accepted job did not start");

  a_round_count: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> cnt <= RND_LAST_256) else $error("round counter out of range");

endmodule

// ----- design/xts_dp.sv -----
// Datapath for the XTS-AES cipher: key stores, on-the-fly key schedule,
// AES round unit, tweak register and output register. Depends on xts_pkg.
module xts_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  xts_pkg::xts_cmd_t     cmd,
  output xts_pkg::xts_status_t  status,
  input  logic                  cfg_valid,
  input  logic                  cfg_index,
  input  logic                  cfg_data,
  input  logic [2:0]            key_index,
  input  logic [63:0]           key_word,
  input  logic [63:0]           sequence_number,
  input  logic [63:0]           block_low,
  input  logic [63:0]           block_high,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [63:0]           result_low,
  output logic [63:0]           result_high
);
  import xts_pkg::*;

  logic klen, dir;
  logic [3:0][63:0] dks, tks;
  logic [127:0] tweak;
  logic [127:0] st;
  logic [255:0] kw, kw_next;
  logic [7:0]   rcon, rcon_next;
  logic         kp;
  logic [127:0] res;

  logic [127:0] key_sel, st_next;
  logic [31:0]  b0, b1, b2, b3, p0, p1, p2, p3;
  logic [7:0]   rc_prev;
  logic         rc_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      klen <= 1'b0;
      dir  <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_KEY_LENGTH) begin
        klen <= cfg_data;
      end else begin
        dir <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dks <= '0;
      tks <= '0;
    end else if (cmd.key_wr) begin
      if (key_index[2]) begin
        tks[key_index[1:0]] <= key_word;
      end else begin
        dks[key_index[1:0]] <= key_word;
      end
    end
  end

  // AES-256 steps alternate between the Rcon core and SubWord only (kp)
  assign rc_step = !klen || (cmd.bwd ? kp : !kp);
  assign rc_prev = inv_xt(rcon);

  always_comb begin
    b0 = '0; b1 = '0; b2 = '0; b3 = '0;
    p0 = '0; p1 = '0; p2 = '0; p3 = '0;
    kw_next   = kw;
    rcon_next = rcon;
    if (cmd.fwd) begin
      if (klen) begin
        b0 = kw[31:0] ^ key_core(kw[255:224], rcon, rc_step);
      end else begin
        b0 = kw[31:0] ^ key_core(kw[127:96], rcon, 1'b1);
      end
      b1 = kw[63:32] ^ b0;
      b2 = kw[95:64] ^ b1;
      b3 = kw[127:96] ^ b2;
      kw_next = klen ? {b3, b2, b1, b0, kw[255:128]} : {kw[255:128], b3, b2, b1, b0};
      if (rc_step) begin
        rcon_next = xt(rcon);
      end
    end else if (cmd.bwd) begin
      if (klen) begin
        p3 = kw[255:224] ^ kw[223:192];
        p2 = kw[223:192] ^ kw[191:160];
        p1 = kw[191:160] ^ kw[159:128];
        p0 = kw[159:128] ^ key_core(kw[127:96], rc_prev, rc_step);
        kw_next = {kw[127:0], p3, p2, p1, p0};
      end else begin
        p3 = kw[127:96] ^ kw[95:64];
        p2 = kw[95:64] ^ kw[63:32];
        p1 = kw[63:32] ^ kw[31:0];
        p0 = kw[31:0] ^ key_core(p3, rc_prev, 1'b1);
        kw_next = {kw[255:128], p3, p2, p1, p0};
      end
      if (rc_step) begin
        rcon_next = rc_prev;
      end
    end
  end

  assign key_sel = (cmd.dec && klen) ? kw[255:128] : kw[127:0];

  always_comb begin
    st_next = st;
    if (cmd.capture) begin
      st_next = cmd.load_tweak ? {64'd0, sequence_number}
                               : ({block_high, block_low} ^ tweak);
    end else if (cmd.add_key) begin
      st_next = st ^ key_sel;
    end else if (cmd.round) begin
      st_next = cmd.dec ? dec_round(st, key_sel, cmd.last) : enc_round(st, key_sel, cmd.last);
    end
  end

  always_ff @(posedge clk) begin
    st <= st_next;
    if (cmd.capture) begin
      kw   <= cmd.load_tweak ? {tks[3], tks[2], tks[1], tks[0]}
                             : {dks[3], dks[2], dks[1], dks[0]};
      rcon <= RCON_FIRST;
      kp   <= 1'b0;
    end else begin
      kw   <= kw_next;
      rcon <= rcon_next;
      if (cmd.fwd || cmd.bwd) begin
        kp <= !kp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tweak <= '0;
    end else if (cmd.finish) begin
      if (cmd.tweak_job) begin
        tweak <= st;
      end else begin
        // multiply by x in GF(2^128)
        tweak <= {tweak[126:0], 1'b0} ^
                 {120'd0, (tweak[127] ? GF128_POLY : GF128_NONE)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && !cmd.tweak_job) begin
      res <= st ^ tweak;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish && !cmd.tweak_job) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign result_low      = res[63:0];
  assign result_high     = res[127:64];
  assign status.klen     = klen;
  assign status.dir      = dir;
  assign status.out_full = out_valid && out_stall;

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish)) else $error("result without finished job");

  a_tweak_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.finish |=> $stable(tweak)) else $error("tweak changed outside finish");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && !cmd.tweak_job) |-> !status.out_full)
    else $error("pending result overwritten");

endmodule

// ----- design/xts_aes_block_cipher.sv -----
// XTS-AES-128/256 cipher, one AES round per cycle, one item at a time.
// Block, encrypt: accept, add round key, rounds, then result registered with tweak;
// decrypt runs the forward key schedule before that. Finish waits while a result is pending.
// Start item: sequence number encrypted under the tweak key into the tweak register.
// Key word item: written when accepted. Synchronous reset clears keys, tweak,
// key length and direction to zero; no result pending.
module xts_aes_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [2:0]  key_index,
  input  logic [63:0] key_word,
  input  logic [63:0] sequence_number,
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_low,
  output logic [63:0] result_high,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data
);
  import xts_pkg::*;

  xts_cmd_t    cmd;
  xts_status_t status;

  assign cfg_ready = 1'b1;

  xts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .status   (status),
    .cmd      (cmd)
  );

  xts_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .key_index       (key_index),
    .key_word        (key_word),
    .sequence_number (sequence_number),
    .block_low       (block_low),
    .block_high      (block_high),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_low      (result_low),
    .result_high     (result_high)
  );

endmodule

// ----- tb/xts_aes_block_cipher_tb.sv -----
// Self-checking testbench for the XTS-AES-128/256 block cipher.
// Predicts each cipher result in SystemVerilog and compares it with the block output.
// Depends on xts_pkg (opcodes, register indexes) and xts_aes_block_cipher.
`timescale 1ns / 1ps

module xts_aes_block_cipher_tb;
  import xts_pkg::*;

  typedef struct {
    logic [1:0]  op;
    logic [2:0]  kidx;
    logic [63:0] kword;
    logic [63:0] sector;
    logic [63:0] blo;
    logic [63:0] bhi;
  } xts_item_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
  } xts_block_t;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic [2:0] key_index = '0;
  logic [63:0] key_word = '0, sequence_number = '0, block_low = '0, block_high = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] result_low, result_high;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic cfg_data = 1'b0;

  xts_aes_block_cipher dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic        mdl_klen, mdl_dir;
  logic [63:0] mdl_dkey [4];
  logic [63:0] mdl_tkey [4];
  logic [127:0] mdl_tweak;

  xts_item_t  pending_items[$];
  xts_block_t expected_blocks[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int hold_cycles = 0;
  bit running = 1'b0;

  logic [7:0] sb [256];
  logic [7:0] isb [256];

  function automatic logic [7:0] mul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gfmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = mul2(a);
    end
    return p;
  endfunction

  // round keys as bytes, key words taken from a store
  function automatic int schedule(input logic [63:0] store [4], input logic klen,
                                  output logic [7:0] rk [240]);
    int nk, nr;
    logic [7:0] t [4];
    logic [7:0] rc, tmp;
    nk = klen ? 8 : 4;
    nr = klen ? 14 : 10;
    rc = 8'h01;
    for (int i = 0; i < 4 * nk; i++) rk[i] = store[i >> 3][8 * (i & 7) +: 8];
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      for (int j = 0; j < 4; j++) t[j] = rk[4 * (i - 1) + j];
      if (i % nk == 0) begin
        tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
        for (int j = 0; j < 4; j++) t[j] = sb[t[j]];
        t[0] ^= rc;
        rc = mul2(rc);
      end else if (nk > 6 && i % nk == 4) begin
        for (int j = 0; j < 4; j++) t[j] = sb[t[j]];
      end
      for (int j = 0; j < 4; j++) rk[4 * i + j] = rk[4 * (i - nk) + j] ^ t[j];
    end
    return nr;
  endfunction

  function automatic logic [127:0] aes_cipher(input logic [63:0] store [4], input logic klen,
                                              input logic inv, input logic [127:0] blk);
    logic [7:0] rk [240];
    logic [7:0] s [16];
    logic [7:0] u [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] res;
    int nr;
    nr = schedule(store, klen, rk);
    for (int i = 0; i < 16; i++) s[i] = blk[8 * i +: 8];
    if (!inv) begin
      for (int i = 0; i < 16; i++) s[i] ^= rk[i];
      for (int r = 1; r <= nr; r++) begin
        for (int c = 0; c < 4; c++)
          for (int i = 0; i < 4; i++) u[i + 4 * c] = sb[s[i + 4 * ((c + i) & 3)]];
        if (r != nr) begin
          for (int c = 0; c < 4; c++) begin
            a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
            u[4*c]   = mul2(a0) ^ mul2(a1) ^ a1 ^ a2 ^ a3;
            u[4*c+1] = a0 ^ mul2(a1) ^ mul2(a2) ^ a2 ^ a3;
            u[4*c+2] = a0 ^ a1 ^ mul2(a2) ^ mul2(a3) ^ a3;
            u[4*c+3] = mul2(a0) ^ a0 ^ a1 ^ a2 ^ mul2(a3);
          end
        end
        for (int i = 0; i < 16; i++) s[i] = u[i] ^ rk[16 * r + i];
      end
    end else begin
      for (int i = 0; i < 16; i++) s[i] ^= rk[16 * nr + i];
      for (int r = nr - 1; r >= 0; r--) begin
        for (int c = 0; c < 4; c++)
          for (int i = 0; i < 4; i++) u[i + 4 * ((c + i) & 3)] = isb[s[i + 4 * c]];
        for (int i = 0; i < 16; i++) s[i] = u[i] ^ rk[16 * r + i];
        if (r != 0) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            s[4*c]   = gfmul(a0, 14) ^ gfmul(a1, 11) ^ gfmul(a2, 13) ^ gfmul(a3, 9);
            s[4*c+1] = gfmul(a0, 9) ^ gfmul(a1, 14) ^ gfmul(a2, 11) ^ gfmul(a3, 13);
            s[4*c+2] = gfmul(a0, 13) ^ gfmul(a1, 9) ^ gfmul(a2, 14) ^ gfmul(a3, 11);
            s[4*c+3] = gfmul(a0, 11) ^ gfmul(a1, 13) ^ gfmul(a2, 9) ^ gfmul(a3, 14);
          end
        end
      end
    end
    for (int i = 0; i < 16; i++) res[8 * i +: 8] = s[i];
    return res;
  endfunction

  task automatic predict_xts(input xts_item_t it);
    logic [127:0] x;
    xts_block_t b;
    case (it.op)
      OP_KEY: begin
        if (it.kidx < 4) mdl_dkey[it.kidx[1:0]] = it.kword;
        else mdl_tkey[it.kidx[1:0]] = it.kword;
      end
      OP_START: mdl_tweak = aes_cipher(mdl_tkey, mdl_klen, 1'b0, {64'd0, it.sector});
      OP_BLOCK: begin
        x = aes_cipher(mdl_dkey, mdl_klen, mdl_dir, {it.bhi, it.blo} ^ mdl_tweak) ^ mdl_tweak;
        b.lo = x[63:0];
        b.hi = x[127:64];
        expected_blocks.push_back(b);
        // multiply tweak by x, reduce into byte 0
        mdl_tweak = {mdl_tweak[126:0], 1'b0} ^ (mdl_tweak[127] ? 128'h87 : 128'h0);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  logic in_stall_q = 1'b0;
  always @(posedge clk) in_stall_q <= in_stall;

  // driver
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_q) begin
        // item taken at the last rising edge
        in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 4) == 0) in_gap = 0;
      end
      if (!(in_valid && in_stall_q)) begin
        if (pending_items.size() != 0 && running && in_gap == 0) begin
          xts_item_t it;
          it = pending_items.pop_front();
          predict_xts(it);
          items_sent++;
          opcode <= it.op;
          key_index <= it.kidx;
          key_word <= it.kword;
          sequence_number <= it.sector;
          block_low <= it.blo;
          block_high <= it.bhi;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end
      end
    end
  end

  // receiver stall and monitor
  int out_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (expected_blocks.size() == 0) begin
        report_mismatch("unexpected result_low", result_low, 64'd0);
      end else begin
        xts_block_t e;
        e = expected_blocks.pop_front();
        if (result_low !== e.lo) report_mismatch("result_low", result_low, e.lo);
        if (result_high !== e.hi) report_mismatch("result_high", result_high, e.hi);
      end
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic xts_item_t make_item(input logic [1:0] op, input logic [2:0] kidx,
                                          input logic [63:0] v0, input logic [63:0] v1,
                                          input logic [63:0] v2);
    xts_item_t it;
    it.op = op; it.kidx = kidx; it.kword = v0; it.sector = v0;
    it.blo = v1; it.bhi = v2;
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_blocks.size() != 0 || in_valid)
      @(posedge clk);
    // a start item may still be running
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_KEY_LENGTH) mdl_klen = val;
    else mdl_dir = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(input int n);
    for (int k = 0; k < n; k++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) pending_items.push_back(make_item(OP_KEY, 3'($urandom), rnd64(), 0, 0));
      else if (r < 18) pending_items.push_back(make_item(OP_START, 3'($urandom), rnd64(), 0, 0));
      else if (r < 21) pending_items.push_back(make_item(OP_UNUSED, 3'($urandom), rnd64(),
                                                         rnd64(), rnd64()));
      else pending_items.push_back(make_item(OP_BLOCK, 3'($urandom), rnd64(), rnd64(), rnd64()));
    end
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      sb[i] = SBOX[i];
      isb[SBOX[i]] = i[7:0];
    end
    mdl_klen = 1'b0; mdl_dir = 1'b0; mdl_tweak = '0;
    for (int i = 0; i < 4; i++) begin
      mdl_dkey[i] = '0;
      mdl_tkey[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    running = 1'b1;

    // directed: block before any start, unused opcode, field extremes
    pending_items.push_back(make_item(OP_BLOCK, 3'd0, '0, '0, '0));
    pending_items.push_back(make_item(OP_UNUSED, 3'd7, '1, '1, '1));
    pending_items.push_back(make_item(OP_BLOCK, 3'd7, '1, '1, '1));
    for (int i = 0; i < 8; i++)
      pending_items.push_back(make_item(OP_KEY, 3'(i), (i % 2) ? '1 : rnd64(), 0, 0));
    pending_items.push_back(make_item(OP_START, 3'd0, '1, 0, 0));
    pending_items.push_back(make_item(OP_BLOCK, 3'd0, 0, '1, '0));
    pending_items.push_back(make_item(OP_START, 3'd0, '0, 0, 0));
    pending_items.push_back(make_item(OP_BLOCK, 3'd0, 0, '0, '1));
    wait_drained();

    // key length, direction in all four settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_KEY_LENGTH, ph[0]);
      write_reg(REG_DIRECTION, ph[1]);
      // well-formed unit: data key, tweak key, start, then random items
      for (int i = 0; i < 8; i++)
        pending_items.push_back(make_item(OP_KEY, 3'(i), rnd64(), 0, 0));
      pending_items.push_back(make_item(OP_START, 3'd0, rnd64(), 0, 0));
      if (ph == 2) hold_cycles = 400;
      queue_random(55);
      wait_drained();
    end

    $display("covered %0d items and %0d cipher results", items_sent, results_seen);
    $display("both key lengths, both directions, key changes inside units, unused opcode");
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
